// ===== hdl/hll_pkg.sv =====
`default_nettype none
package hll_pkg;

	localparam int INDEX_BITS = 10;
	localparam int HASH_BITS  = 32;
	localparam int REM_BITS   = HASH_BITS - INDEX_BITS;
	localparam int NUM_REGS   = 1 << INDEX_BITS;
	localparam int RANK_W     = 5;
	localparam int SUM_W      = 43;
	localparam int CNT_W      = 11;
	localparam int MERGE_IDX_W = 10;

	localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(HASH_BITS + 1 - INDEX_BITS);

	// sum and zero count after a clear
	localparam logic [SUM_W-1:0] SUM_RESET  = SUM_W'(NUM_REGS) << HASH_BITS;
	localparam logic [CNT_W-1:0] ZCNT_RESET = CNT_W'(NUM_REGS);

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_MERGE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// one plus leading zeros of the hash bits below the index
	function automatic logic [RANK_W-1:0] rank_of(input logic [HASH_BITS-1:0] hash);
		logic [RANK_W-1:0] r;
		r = MAX_RANK;
		for (int i = 0; i < REM_BITS; i++) begin
			if (hash[i]) begin
				r = RANK_W'(REM_BITS - i);
			end
		end
		return r;
	endfunction

	// 2^(32 - rank) in the fixed-point sum format
	function automatic logic [SUM_W-1:0] weight_of(input logic [RANK_W-1:0] rank);
		logic [5:0] sh;
		sh = 6'(HASH_BITS) - {1'b0, rank};
		return {{(SUM_W-1){1'b0}}, 1'b1} << sh;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/hll_ram.sv =====
`default_nettype none
module hll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/hyperloglog_register_update.sv =====
// channel   | valid     | ready     | payload
// ----------+-----------+-----------+------------------------------------------------
// request   | in_valid  | in_ready  | cmd, hash_value, merge_index, merge_rank
// result    | out_valid | out_ready | harmonic_sum, zero_count, touched_index,
//           |           |           | touched_rank, rank_changed
//
// add, merge and the unused command: the request cycle issues the read of the rank
// memory, the next cycle writes back the rank if it grew; a new request is taken
// the cycle after that step, so requests do not overlap
// clear sweeps the memory one entry a cycle, then gives its result
// after reset the same sweep runs with in_ready low and gives no result
// a held result stalls the write-back or the clear result of the following request
`default_nettype none
module hyperloglog_register_update (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     cmd,
	input  wire logic [hll_pkg::HASH_BITS-1:0]  hash_value,
	input  wire logic [hll_pkg::MERGE_IDX_W-1:0] merge_index,
	input  wire logic [hll_pkg::RANK_W-1:0]     merge_rank,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [hll_pkg::SUM_W-1:0]      harmonic_sum,
	output logic      [hll_pkg::CNT_W-1:0]      zero_count,
	output logic      [hll_pkg::MERGE_IDX_W-1:0] touched_index,
	output logic      [hll_pkg::RANK_W-1:0]     touched_rank,
	output logic                                rank_changed
);

	// controller states
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_RMW     = 2'd1;
	localparam logic [1:0] ST_CLEAR   = 2'd2;
	localparam logic [1:0] ST_CLR_OUT = 2'd3;

	logic [1:0] state_q;

	// request held through the read-modify-write
	logic [1:0]                        cmd_s1;
	logic [hll_pkg::INDEX_BITS-1:0]    idx_s1;
	logic [hll_pkg::RANK_W-1:0]        rank_s1;

	// running sketch totals
	logic [hll_pkg::SUM_W-1:0]         sum_q;
	logic [hll_pkg::CNT_W-1:0]         zcnt_q;

	// clearing sweep
	logic [hll_pkg::INDEX_BITS-1:0]    clr_cnt_q;
	logic                              clr_reply_q;

	logic                              out_valid_q;

	// memory port signals
	logic                              ram_we;
	logic [hll_pkg::INDEX_BITS-1:0]    ram_waddr;
	logic [hll_pkg::RANK_W-1:0]        ram_wdata;
	logic                              ram_re;
	logic [hll_pkg::INDEX_BITS-1:0]    ram_raddr;
	logic [hll_pkg::RANK_W-1:0]        ram_rdata;

	logic                              accept;
	logic                              out_free;
	logic                              commit;
	logic                              is_upd;
	logic                              grow;
	logic [hll_pkg::SUM_W-1:0]         sum_next;
	logic [hll_pkg::CNT_W-1:0]         zcnt_next;
	logic [hll_pkg::INDEX_BITS-1:0]    req_idx;
	logic [hll_pkg::RANK_W-1:0]        req_rank;
	logic                              sweep_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// the result register can take a new result this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign commit    = (state_q == ST_RMW) && out_free;
	assign sweep_last = (clr_cnt_q == hll_pkg::INDEX_BITS'(hll_pkg::NUM_REGS - 1));

	// register index and candidate rank of the incoming request
	always_comb begin
		if (cmd == hll_pkg::CMD_ADD) begin
			req_idx  = hash_value[hll_pkg::HASH_BITS-1 -: hll_pkg::INDEX_BITS];
			req_rank = hll_pkg::rank_of(hash_value);
		end else begin
			req_idx  = merge_index[hll_pkg::INDEX_BITS-1:0];
			// ranks above what add can produce are saturated
			req_rank = (merge_rank > hll_pkg::MAX_RANK) ? hll_pkg::MAX_RANK : merge_rank;
		end
	end

	// modify step: the stored rank arrives from memory this cycle
	assign is_upd = (cmd_s1 == hll_pkg::CMD_ADD) || (cmd_s1 == hll_pkg::CMD_MERGE);
	assign grow   = is_upd && (rank_s1 > ram_rdata);

	always_comb begin
		sum_next  = sum_q;
		zcnt_next = zcnt_q;
		if (grow) begin
			// new weight is smaller than the old one, so this never underflows
			sum_next = sum_q - (hll_pkg::weight_of(ram_rdata) - hll_pkg::weight_of(rank_s1));
			if (ram_rdata == '0) begin
				zcnt_next = zcnt_q - hll_pkg::CNT_W'(1);
			end
		end
	end

	// memory access: sweep writes zeros, otherwise write back a grown rank
	always_comb begin
		ram_re    = accept;
		ram_raddr = req_idx;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = commit && grow;
			ram_waddr = idx_s1;
			ram_wdata = rank_s1;
		end
	end

	hll_ram #(
		.WIDTH (hll_pkg::RANK_W),
		.DEPTH (hll_pkg::NUM_REGS)
	) u_rank_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd;
			idx_s1  <= req_idx;
			rank_s1 <= req_rank;
		end
	end

	// control and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_reply_q <= 1'b0;
			sum_q       <= hll_pkg::SUM_RESET;
			zcnt_q      <= hll_pkg::ZCNT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			// a new result is loaded, or the held one leaves
			if (commit || ((state_q == ST_CLR_OUT) && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == hll_pkg::CMD_CLEAR) begin
							state_q     <= ST_CLEAR;
							clr_cnt_q   <= '0;
							clr_reply_q <= 1'b1;
						end else begin
							state_q <= ST_RMW;
						end
					end
				end
				ST_RMW: begin
					// wait here while the previous result is still held
					if (commit) begin
						sum_q       <= sum_next;
						zcnt_q      <= zcnt_next;
						state_q     <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + hll_pkg::INDEX_BITS'(1);
					if (sweep_last) begin
						sum_q   <= hll_pkg::SUM_RESET;
						zcnt_q  <= hll_pkg::ZCNT_RESET;
						state_q <= clr_reply_q ? ST_CLR_OUT : ST_IDLE;
					end
				end
				ST_CLR_OUT: begin
					if (out_free) begin
						clr_reply_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (commit) begin
			harmonic_sum  <= sum_next;
			zero_count    <= zcnt_next;
			touched_index <= is_upd ? hll_pkg::MERGE_IDX_W'(idx_s1) : '0;
			touched_rank  <= grow ? rank_s1 : (is_upd ? ram_rdata : '0);
			rank_changed  <= grow;
		end else if ((state_q == ST_CLR_OUT) && out_free) begin
			harmonic_sum  <= sum_q;
			zero_count    <= zcnt_q;
			touched_index <= '0;
			touched_rank  <= '0;
			rank_changed  <= 1'b0;
		end
	end

endmodule
`default_nettype wire
